// ===== rtl/tlq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlq_pkg
// Shared constants, register indexes and the sideband type of the thick line
// quad expansion pipeline.
// ============================================================================
package tlq_pkg;

  localparam int COORD_FRAC_BITS = 16;

  // depth floor, ceil(0.001) in LSB, and the short-segment limit, ceil(1e-6)
  localparam int DEPTH_FLOOR = (2 ** COORD_FRAC_BITS + 999) / 1000;
  localparam int ZERO_LEN    = (2 ** COORD_FRAC_BITS + 999999) / 1000000;
  localparam int ZL_W        = $clog2(ZERO_LEN + 1);

  // offset = unit(Q1.30) * width(Q8.8) scaled back to Q.F
  localparam int RND_SHIFT = 39 - COORD_FRAC_BITS;
  localparam int PROD_W    = 47;
  localparam int OFF_W     = PROD_W + 1 - RND_SHIFT;
  localparam int SUM_W     = ((OFF_W > 31) ? OFF_W : 31) + 2;

  // pipeline stage counts
  localparam int NORM_STAGES  = 3;
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 31;
  localparam int UNIT_STAGE   = 1 + NORM_STAGES + SQRT_STAGES + DIV_STAGES;
  localparam int WNUM         = 24 + COORD_FRAC_BITS;
  localparam int WIDTH_STAGES = WNUM + 2;
  localparam int WIDTH_IN     = UNIT_STAGE - WIDTH_STAGES;
  localparam int PIPE_DEPTH   = UNIT_STAGE + 1;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MIN   = 2'd0;
  localparam logic [1:0] REG_MAX   = 2'd1;
  localparam logic [1:0] REG_FOCAL = 2'd2;

  localparam logic [15:0] MIN_RESET   = 16'd256;
  localparam logic [15:0] MAX_RESET   = 16'd2560;
  localparam logic [23:0] FOCAL_RESET = 24'd128000;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] sd;
    logic [31:0] ed;
    logic        nxneg;
    logic        nyneg;
    logic        zlen;
  } sb_t;

endpackage

// ===== rtl/tlq_norm.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlq_norm
// Scales both absolute differences by the same shift, the larger into
// [2^30, 2^31), and forms the sum of their squares. Three register stages.
// ============================================================================
module tlq_norm import tlq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] ax,
  input  logic [32:0] ay,
  output logic [62:0] sum,
  output logic [30:0] ax_n,
  output logic [30:0] ay_n
);

  logic [32:0] m;
  logic [4:0]  sh;
  logic [30:0] a2_next, b2_next;
  logic [30:0] a2, b2, a3, b3;
  logic [61:0] sqa, sqb;

  always_comb begin
    m  = (ax > ay) ? ax : ay;
    sh = '0;
    for (int k = 0; k < 31; k++) begin
      if (m[k]) sh = 5'(30 - k);
    end
    if (m[32] || m[31]) begin
      a2_next = ax[31:1];
      b2_next = ay[31:1];
    end else begin
      a2_next = ax[30:0] << sh;
      b2_next = ay[30:0] << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2   <= a2_next;
      b2   <= b2_next;
      sqa  <= 62'(a2) * 62'(a2);
      sqb  <= 62'(b2) * 62'(b2);
      a3   <= a2;
      b3   <= b2;
      sum  <= 63'(sqa) + 63'(sqb);
      ax_n <= a3;
      ay_n <= b3;
    end
  end

endmodule

// ===== rtl/tlq_isqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlq_isqrt
// Pipelined integer square root, one result bit per stage, with the two
// scaled differences carried alongside.
// ============================================================================
module tlq_isqrt import tlq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] v,
  input  logic [30:0] a_in,
  input  logic [30:0] b_in,
  output logic [31:0] root,
  output logic [30:0] a_out,
  output logic [30:0] b_out
);

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
    logic [63:0] vr;
    logic [30:0] a;
    logic [30:0] b;
  } sq_st_t;

  function automatic sq_st_t sq_step(sq_st_t s);
    sq_st_t     o;
    logic [34:0] t;
    logic [34:0] trial;
    o     = s;
    t     = {s.rem, s.vr[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.vr  = {s.vr[61:0], 2'b00};
    if (t >= trial) begin
      o.rem  = 33'(t - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = t[32:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  sq_st_t st_in;
  sq_st_t st [SQRT_STAGES];

  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.vr   = {1'b0, v};
    st_in.a    = a_in;
    st_in.b    = b_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step(st_in);
      for (int k = 1; k < SQRT_STAGES; k++) begin
        st[k] <= sq_step(st[k-1]);
      end
    end
  end

  assign root  = st[SQRT_STAGES-1].root;
  assign a_out = st[SQRT_STAGES-1].a;
  assign b_out = st[SQRT_STAGES-1].b;

endmodule

// ===== rtl/tlq_udiv.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlq_udiv
// Two-lane pipelined restoring divider: (a << 30) / den, one quotient bit
// per stage, both lanes sharing the divisor.
// ============================================================================
module tlq_udiv import tlq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] den,
  input  logic [30:0] a,
  input  logic [30:0] b,
  output logic [30:0] qa,
  output logic [30:0] qb
);

  typedef struct packed {
    logic [31:0] den;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [30:0] qa;
    logic [30:0] qb;
    logic        na;
    logic        nb;
  } dv_st_t;

  function automatic dv_st_t dv_step(dv_st_t s);
    dv_st_t      o;
    logic [32:0] ta, tb;
    o  = s;
    ta = {s.ra, s.na};
    tb = {s.rb, s.nb};
    if (ta >= {1'b0, s.den}) begin
      o.ra = 32'(ta - {1'b0, s.den});
      o.qa = {s.qa[29:0], 1'b1};
    end else begin
      o.ra = ta[31:0];
      o.qa = {s.qa[29:0], 1'b0};
    end
    if (tb >= {1'b0, s.den}) begin
      o.rb = 32'(tb - {1'b0, s.den});
      o.qb = {s.qb[29:0], 1'b1};
    end else begin
      o.rb = tb[31:0];
      o.qb = {s.qb[29:0], 1'b0};
    end
    o.na = 1'b0;
    o.nb = 1'b0;
    return o;
  endfunction

  dv_st_t st_in;
  dv_st_t st [DIV_STAGES];

  always_comb begin
    st_in.den = den;
    st_in.ra  = {2'b00, a[30:1]};
    st_in.rb  = {2'b00, b[30:1]};
    st_in.qa  = '0;
    st_in.qb  = '0;
    st_in.na  = a[0];
    st_in.nb  = b[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= dv_step(st_in);
      for (int k = 1; k < DIV_STAGES; k++) begin
        st[k] <= dv_step(st[k-1]);
      end
    end
  end

  assign qa = st[DIV_STAGES-1].qa;
  assign qb = st[DIV_STAGES-1].qb;

endmodule

// ===== rtl/tlq_width.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlq_width
// Perspective line width at both ends: focal / (10 * floored depth),
// pipelined restoring division, then clamp to the configured range.
// ============================================================================
module tlq_width import tlq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sd,
  input  logic [31:0] ed,
  input  logic [23:0] focal_length,
  input  logic [15:0] min_thickness,
  input  logic [15:0] max_thickness,
  output logic [15:0] ws,
  output logic [15:0] we
);

  typedef struct packed {
    logic [34:0]      dena;
    logic [34:0]      denb;
    logic [34:0]      ra;
    logic [34:0]      rb;
    logic [WNUM-1:0]  num;
    logic [WNUM-1:0]  qa;
    logic [WNUM-1:0]  qb;
  } wd_st_t;

  function automatic logic [34:0] depth_den(logic [31:0] d);
    logic [31:0] df;
    df = ($signed(d) < $signed(32'(DEPTH_FLOOR))) ? 32'(DEPTH_FLOOR) : d;
    return ({3'b000, df} << 3) + ({3'b000, df} << 1);
  endfunction

  function automatic wd_st_t wd_step(wd_st_t s);
    wd_st_t      o;
    logic [35:0] ta, tb;
    o     = s;
    ta    = {s.ra, s.num[WNUM-1]};
    tb    = {s.rb, s.num[WNUM-1]};
    o.num = {s.num[WNUM-2:0], 1'b0};
    if (ta >= {1'b0, s.dena}) begin
      o.ra = 35'(ta - {1'b0, s.dena});
      o.qa = {s.qa[WNUM-2:0], 1'b1};
    end else begin
      o.ra = ta[34:0];
      o.qa = {s.qa[WNUM-2:0], 1'b0};
    end
    if (tb >= {1'b0, s.denb}) begin
      o.rb = 35'(tb - {1'b0, s.denb});
      o.qb = {s.qb[WNUM-2:0], 1'b1};
    end else begin
      o.rb = tb[34:0];
      o.qb = {s.qb[WNUM-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [15:0] clamp(logic [WNUM-1:0] q, logic [15:0] lo,
                                        logic [15:0] hi);
    priority if (q < WNUM'(lo)) return lo;
    else if (q > WNUM'(hi))     return hi;
    else                        return q[15:0];
  endfunction

  wd_st_t prep;
  wd_st_t st [WNUM];

  always_ff @(posedge clk) begin
    if (en) begin
      prep.dena <= depth_den(sd);
      prep.denb <= depth_den(ed);
      prep.ra   <= '0;
      prep.rb   <= '0;
      prep.num  <= {focal_length, COORD_FRAC_BITS'(0)};
      prep.qa   <= '0;
      prep.qb   <= '0;
      st[0]     <= wd_step(prep);
      for (int k = 1; k < WNUM; k++) begin
        st[k] <= wd_step(st[k-1]);
      end
      ws <= clamp(st[WNUM-1].qa, min_thickness, max_thickness);
      we <= clamp(st[WNUM-1].qb, min_thickness, max_thickness);
    end
  end

endmodule

// ===== rtl/thick_line_quad_expand_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thick_line_quad_expand_unit
// Pipeline: input register, normalisation, the 32-stage square root and the
//   31-stage normal divider in series, then offset products and output register.
// Throughput: one segment per cycle; the whole pipeline holds while an
//   output beat waits.
// Reset: synchronous; clears valid bits and loads the register defaults.
// ============================================================================
module thick_line_quad_expand_unit import tlq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, end_x, end_y, start_depth, end_depth
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // start_left_x, start_left_y, start_right_x, start_right_y, end_left_x,
  // end_left_y, end_right_x, end_right_y, start_depth_out, end_depth_out
  output logic [319:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] min_thickness, max_thickness;
  logic [23:0] focal_length;

  logic        en;
  logic [32:0] dx, dy, ax, ay, ax1, ay1;
  logic [ZL_W-1:0] axl, ayl;
  logic [2*ZL_W:0] zl_sq;
  sb_t         sb_in;
  sb_t         sb [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] vld;

  logic [62:0] sq_sum;
  logic [30:0] ax_n, ay_n, ax_r, ay_r;
  logic [31:0] len;
  logic [30:0] ux, uy;
  logic [15:0] ws, we;
  logic [PROD_W-1:0] p_sx, p_sy, p_ex, p_ey;
  logic [SUM_W-1:0]  o_sx, o_sy, o_ex, o_ey;
  logic [319:0]      m_tdata_next;

  localparam logic [2*ZL_W:0] ZL_SQ = (2*ZL_W+1)'(ZERO_LEN * ZERO_LEN);

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_thickness <= MIN_RESET;
      max_thickness <= MAX_RESET;
      focal_length  <= FOCAL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MIN:   min_thickness <= pwdata[15:0];
        REG_MAX:   max_thickness <= pwdata[15:0];
        REG_FOCAL: focal_length  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MIN:   prdata = {16'b0, min_thickness};
      REG_MAX:   prdata = {16'b0, max_thickness};
      REG_FOCAL: prdata = {8'b0, focal_length};
      default:   prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    dx    = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
    dy    = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
    ax    = dx[32] ? 33'(-dx) : dx;
    ay    = dy[32] ? 33'(-dy) : dy;
    axl   = ax[ZL_W-1:0];
    ayl   = ay[ZL_W-1:0];
    zl_sq = (2*ZL_W+1)'(axl * axl) + (2*ZL_W+1)'(ayl * ayl);
    sb_in.sx    = s_tdata[31:0];
    sb_in.sy    = s_tdata[63:32];
    sb_in.ex    = s_tdata[95:64];
    sb_in.ey    = s_tdata[127:96];
    sb_in.sd    = s_tdata[159:128];
    sb_in.ed    = s_tdata[191:160];
    sb_in.nxneg = !dy[32] && (dy != '0);
    sb_in.nyneg = dx[32];
    sb_in.zlen  = (ax < 33'(ZERO_LEN)) && (ay < 33'(ZERO_LEN)) && (zl_sq < ZL_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[PIPE_DEPTH-2:0], s_tvalid};
      m_tvalid <= vld[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1   <= ax;
      ay1   <= ay;
      sb[0] <= sb_in;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // ---------------- normal and width ----------------
  tlq_norm u_norm (
    .clk  (clk),
    .en   (en),
    .ax   (ax1),
    .ay   (ay1),
    .sum  (sq_sum),
    .ax_n (ax_n),
    .ay_n (ay_n)
  );

  tlq_isqrt u_isqrt (
    .clk   (clk),
    .en    (en),
    .v     (sq_sum),
    .a_in  (ax_n),
    .b_in  (ay_n),
    .root  (len),
    .a_out (ax_r),
    .b_out (ay_r)
  );

  tlq_udiv u_udiv (
    .clk (clk),
    .en  (en),
    .den (len),
    .a   (ay_r),
    .b   (ax_r),
    .qa  (ux),
    .qb  (uy)
  );

  tlq_width u_width (
    .clk           (clk),
    .en            (en),
    .sd            (sb[WIDTH_IN-1].sd),
    .ed            (sb[WIDTH_IN-1].ed),
    .focal_length  (focal_length),
    .min_thickness (min_thickness),
    .max_thickness (max_thickness),
    .ws            (ws),
    .we            (we)
  );

  // ---------------- offsets and corners ----------------
  function automatic logic [SUM_W-1:0] soff(logic [PROD_W-1:0] p, logic neg,
                                            logic z);
    logic [PROD_W:0]  r;
    logic [SUM_W-1:0] m;
    r = {1'b0, p} + ((PROD_W+1)'(1) << (RND_SHIFT - 1));
    m = SUM_W'(r[PROD_W:RND_SHIFT]);
    if (z)        return '0;
    else if (neg) return SUM_W'(-m);
    else          return m;
  endfunction

  function automatic logic [31:0] sat32(logic [SUM_W-1:0] v);
    if (v[SUM_W-1:31] == {(SUM_W-31){v[SUM_W-1]}}) return v[31:0];
    else if (v[SUM_W-1])                          return 32'h8000_0000;
    else                                          return 32'h7fff_ffff;
  endfunction

  function automatic logic [SUM_W-1:0] sx32(logic [31:0] v);
    return {{(SUM_W-32){v[31]}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_sx <= PROD_W'(ux) * PROD_W'(ws);
      p_sy <= PROD_W'(uy) * PROD_W'(ws);
      p_ex <= PROD_W'(ux) * PROD_W'(we);
      p_ey <= PROD_W'(uy) * PROD_W'(we);
    end
  end

  always_comb begin
    o_sx = soff(p_sx, sb[PIPE_DEPTH-1].nxneg, sb[PIPE_DEPTH-1].zlen);
    o_sy = soff(p_sy, sb[PIPE_DEPTH-1].nyneg, sb[PIPE_DEPTH-1].zlen);
    o_ex = soff(p_ex, sb[PIPE_DEPTH-1].nxneg, sb[PIPE_DEPTH-1].zlen);
    o_ey = soff(p_ey, sb[PIPE_DEPTH-1].nyneg, sb[PIPE_DEPTH-1].zlen);
    m_tdata_next[31:0]    = sat32(sx32(sb[PIPE_DEPTH-1].sx) + o_sx);
    m_tdata_next[63:32]   = sat32(sx32(sb[PIPE_DEPTH-1].sy) + o_sy);
    m_tdata_next[95:64]   = sat32(sx32(sb[PIPE_DEPTH-1].sx) - o_sx);
    m_tdata_next[127:96]  = sat32(sx32(sb[PIPE_DEPTH-1].sy) - o_sy);
    m_tdata_next[159:128] = sat32(sx32(sb[PIPE_DEPTH-1].ex) + o_ex);
    m_tdata_next[191:160] = sat32(sx32(sb[PIPE_DEPTH-1].ey) + o_ey);
    m_tdata_next[223:192] = sat32(sx32(sb[PIPE_DEPTH-1].ex) - o_ex);
    m_tdata_next[255:224] = sat32(sx32(sb[PIPE_DEPTH-1].ey) - o_ey);
    m_tdata_next[287:256] = sb[PIPE_DEPTH-1].sd;
    m_tdata_next[319:288] = sb[PIPE_DEPTH-1].ed;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the thick line quad expansion unit. Segments go in
// on the input stream while an in-bench fixed-point width and normal
// calculation predicts the four quad corners; every output beat is checked
// field by field. Width limits and focal length are reprogrammed between
// phases over the register port, extremes included.
// ============================================================================
module tb import tlq_pkg::*; ();

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [319:0] m_tdata;
  logic         psel, penable, pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;

  thick_line_quad_expand_unit i_dut (.*);

  localparam longint ONE_Q = 64'd1 << COORD_FRAC_BITS;
  localparam longint DFLOOR = (ONE_Q + 999) / 1000;
  localparam longint ZLEN = (ONE_Q + 999999) / 1000000;

  logic [15:0] min_w, max_w;
  logic [23:0] focal;

  logic [191:0] segment_q[$];
  logic [319:0] quad_q[$];
  int errors, beats_in, beats_out;
  int send_idle, recv_idle;
  bit send_hold;
  bit in_taken;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned line_width(longint d);
    longint unsigned w;
    if (d < DFLOOR) d = DFLOOR;
    w = (longint'(focal) << COORD_FRAC_BITS) / (longint'(d) * 10);
    if (w < min_w) return min_w;
    if (w > max_w) return max_w;
    return w;
  endfunction

  function automatic longint corner_shift(longint unsigned u, bit neg, longint unsigned w);
    longint unsigned p;
    p = (u * w + (64'd1 << (38 - COORD_FRAC_BITS))) >> (39 - COORD_FRAC_BITS);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [319:0] quad_corners(logic [191:0] seg);
    longint sx, sy, ex, ey, dx, dy, oxs, oys, oxe, oye;
    longint unsigned ax, ay, m, len, ux, uy, ws, we;
    bit nxn, nyn;
    logic [319:0] r;
    sx = sx32(seg[31:0]);
    sy = sx32(seg[63:32]);
    ex = sx32(seg[95:64]);
    ey = sx32(seg[127:96]);
    dx = ex - sx;
    dy = ey - sy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    oxs = 0; oys = 0; oxe = 0; oye = 0;
    if (!(ax < ZLEN && ay < ZLEN && ax * ax + ay * ay < ZLEN * ZLEN)) begin
      nxn = dy > 0;
      nyn = dx < 0;
      m = ax > ay ? ax : ay;
      if (m >= (64'd1 << 31)) begin
        ax >>= 1;
        ay >>= 1;
      end else begin
        while (m < (64'd1 << 30)) begin
          m <<= 1; ax <<= 1; ay <<= 1;
        end
      end
      len = root64(ax * ax + ay * ay);
      ux = (ay << 30) / len;
      uy = (ax << 30) / len;
      ws = line_width(sx32(seg[159:128]));
      we = line_width(sx32(seg[191:160]));
      oxs = corner_shift(ux, nxn, ws);
      oys = corner_shift(uy, nyn, ws);
      oxe = corner_shift(ux, nxn, we);
      oye = corner_shift(uy, nyn, we);
    end
    r[31:0]    = clamp32(sx + oxs);
    r[63:32]   = clamp32(sy + oys);
    r[95:64]   = clamp32(sx - oxs);
    r[127:96]  = clamp32(sy - oys);
    r[159:128] = clamp32(ex + oxe);
    r[191:160] = clamp32(ey + oye);
    r[223:192] = clamp32(ex - oxe);
    r[255:224] = clamp32(ey - oye);
    r[319:256] = seg[191:128];
    return r;
  endfunction

  task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s field %0d: got %h want %h", what, idx, got, want);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) s_tvalid <= 1'b0;
    else if (!s_tvalid || in_taken) begin
      if (segment_q.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_idle) begin
        s_tvalid <= 1'b1;
        s_tdata  <= segment_q[0];
      end else s_tvalid <= 1'b0;
    end
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  // input side pops; also predicts
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      quad_q.push_back(quad_corners(s_tdata));
      void'(segment_q.pop_front());
      beats_in++;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [319:0] want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (quad_q.size() == 0) begin
        errors++;
        $display("output beat with nothing expected");
      end else begin
        want = quad_q.pop_front();
        for (int f = 0; f < 10; f++)
          if (m_tdata[f*32 +: 32] !== want[f*32 +: 32])
            report("corner", f, m_tdata[f*32 +: 32], want[f*32 +: 32]);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_MIN: min_w = val[15:0];
      REG_MAX: max_w = val[15:0];
      default: focal = val[23:0];
    endcase
  endtask

  task automatic drain();
    while (segment_q.size() > 0 || quad_q.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(8000)) - 4000) << 16 | $urandom_range(65535);
    endcase
  endfunction

  function automatic logic [31:0] rnd_depth();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(80);
      default: return $urandom_range(32'h0100_0000, 32'h0000_4000);
    endcase
  endfunction

  task automatic add_seg(logic [31:0] a, b, c, d, e, f);
    segment_q.push_back({f, e, d, c, b, a});
  endtask

  task automatic random_phase(int n);
    logic [31:0] x, y;
    repeat (n) begin
      x = rnd_coord();
      y = rnd_coord();
      if ($urandom_range(9) == 0)
        add_seg(x, y, x + $urandom_range(1), y - $urandom_range(1), rnd_depth(), rnd_depth());
      else if ($urandom_range(3) == 0)
        add_seg(x, y, x + $urandom_range(200) - 100, y + $urandom_range(200) - 100,
                rnd_depth(), rnd_depth());
      else add_seg(x, y, rnd_coord(), rnd_coord(), rnd_depth(), rnd_depth());
    end
  endtask

  initial begin
    errors = 0; beats_in = 0; beats_out = 0;
    send_idle = 35; recv_idle = 48; send_hold = 0; in_taken = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; m_tready = 0;
    min_w = MIN_RESET; max_w = MAX_RESET; focal = FOCAL_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: zero length, near-zero, axis, extremes, depth floor, saturation
    add_seg(0, 0, 0, 0, 32'h10000, 32'h10000);
    add_seg(32'h1234, 32'h5678, 32'h1234, 32'h5678, 0, 32'hffffffff);
    add_seg(0, 0, 1, 0, 32'h10000, 32'h20000);
    add_seg(0, 0, 0, 1, 0, 32'h80000000);
    add_seg(0, 0, 32'h100000, 0, 65, 66);
    add_seg(0, 0, 0, 32'h100000, 67, 32'h7fffffff);
    add_seg(0, 0, 32'hfff00000, 0, 32'h100, 32'h10000);
    add_seg(0, 0, 0, 32'hfff00000, 32'h100000, 32'h1000);
    add_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, 1);
    add_seg(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0);
    add_seg(32'h7fffffff, 32'h7fffffff, 32'h7ffff000, 32'h7fffffff, 0, 0);
    add_seg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80001000, 0, 0);
    add_seg(32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h50000, 32'h50000);
    add_seg(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'h7fff0000, 32'hc0000000);
    add_seg(0, 0, 32'h30000, 32'h40000, 32'h8000, 32'h8000);
    drain();
    send_hold = 1;

    reg_write(REG_MIN, 32'hffff);
    reg_write(REG_MAX, 32'h0);
    reg_write(REG_FOCAL, 32'hffffff);
    send_hold = 0;
    random_phase(150);
    drain();

    reg_write(REG_MIN, 0);
    reg_write(REG_MAX, 32'hffff);
    reg_write(REG_FOCAL, 0);
    random_phase(150);
    drain();

    reg_write(REG_FOCAL, 32'hffffff);
    random_phase(200);
    drain();

    send_idle = 48; recv_idle = 35;
    reg_write(REG_MIN, $urandom_range(2000));
    reg_write(REG_MAX, $urandom_range(65535, 1000));
    reg_write(REG_FOCAL, $urandom_range(24'hffffff));
    random_phase(450);
    drain();

    send_idle = 0; recv_idle = 0;
    reg_write(REG_MIN, MIN_RESET);
    reg_write(REG_MAX, MAX_RESET);
    reg_write(REG_FOCAL, FOCAL_RESET);
    random_phase(500);
    drain();

    $display("covered %0d segments in, %0d quads out, across six register settings",
             beats_in, beats_out);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
